// ===== rtl/slc_pkg.sv =====
// Package for the set-associative LRU cache tag store.
// Holds default sizes, register codes, reset values and the word types.
// No dependencies.
package slc_pkg;

    localparam int SLC_NUM_SETS  = 4096;
    localparam int SLC_MAX_WAYS  = 8;
    localparam int SLC_ADDR_BITS = 32;

    localparam int TAG_W     = 32;
    localparam int IDX_W     = 12;
    localparam int CNT_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 5;

    localparam logic [3:0] IDX_BITS_CAP = 4'd12;

    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS_USED   = 2'd2;

    localparam logic [4:0] RST_OFFSET_BITS = 5'd5;
    localparam logic [3:0] RST_INDEX_BITS  = 4'd12;
    localparam logic [3:0] RST_WAYS_USED   = 4'd4;

    typedef struct packed {
        logic        [31:0] base_address;
        logic signed [31:0] address_offset;
    } t_slc_in;

    typedef struct packed {
        logic             hit;
        logic             evicted;
        logic [IDX_W-1:0] set_index;
        logic [TAG_W-1:0] line_tag;
        logic [CNT_W-1:0] hit_total;
        logic [CNT_W-1:0] miss_total;
    } t_slc_out;

    typedef struct packed {
        logic hit;
        logic evicted;
    } t_slc_status;

endpackage

// ===== rtl/set_assoc_lru_cache_tags.sv =====
// Top level of the set-associative cache tag store with true LRU replacement.
// Depends on slc_pkg and slc_way_logic; holds the tag and LRU set memories.
//
//   channel   direction  handshake                 word
//   in        input      i_in_valid / o_in_stall   i_in_data  (t_slc_in)
//   out       output     o_out_valid / i_out_stall o_out_data (t_slc_out)
//   cfg       input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// An access goes through accept, address split, set read and update when NUM_SETS is a
// power of two; otherwise the set remainder comes after the address split, as a reciprocal
// multiply and then a subtract.
// The set read and the write back on the single-port set memories are separate steps.
// After reset, a clearing pass over all NUM_SETS sets zeroes the valid and LRU memory;
// no access is accepted until it ends, while configuration writes are taken.
// The result sits in an output register, so the next access is accepted while it waits.
module set_assoc_lru_cache_tags import slc_pkg::*; #(
    parameter int NUM_SETS  = SLC_NUM_SETS,
    parameter int MAX_WAYS  = SLC_MAX_WAYS,
    parameter int ADDR_BITS = SLC_ADDR_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_slc_in              i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_slc_out             o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    localparam int  SAW       = NUM_SETS > 1 ? $clog2(NUM_SETS) : 1;
    localparam int  RW        = MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1;
    localparam int  WW        = MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1;
    localparam int  META_W    = MAX_WAYS * (RW + 1);
    localparam int  TROW_W    = MAX_WAYS * TAG_W;
    localparam bit  SETS_POW2 = (NUM_SETS & (NUM_SETS - 1)) == 0;
    localparam int  MOD_STEPS = 2;
    localparam int  MCW       = $clog2(MOD_STEPS);
    localparam int  RCP_SH    = IDX_W + SAW;
    localparam int  RCP_W     = IDX_W + 2;
    localparam int  PRD_W     = IDX_W + RCP_W;

    localparam logic [RCP_W-1:0] RCP_M   = RCP_W'((2 ** RCP_SH + NUM_SETS - 1) / NUM_SETS);
    localparam logic [IDX_W-1:0] SETS_LO = IDX_W'(NUM_SETS);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_ADDR = 3'd2;
    localparam logic [2:0] S_MOD  = 3'd3;
    localparam logic [2:0] S_RD   = 3'd4;
    localparam logic [2:0] S_UPD  = 3'd5;

    logic [2:0]           r_state;
    logic [2:0]           n_state;
    logic [SAW-1:0]       r_clr;
    logic [MCW-1:0]       r_mod_cnt;
    logic                 r_out_valid;
    logic [CNT_W-1:0]     r_hit_cnt;
    logic [CNT_W-1:0]     r_miss_cnt;
    logic [4:0]           r_ob;
    logic [3:0]           r_ib;
    logic [3:0]           r_ways;

    logic [ADDR_BITS-1:0] r_ea;
    logic [IDX_W-1:0]     r_idx;
    logic [TAG_W-1:0]     r_tag;
    logic [SAW-1:0]       r_set;
    logic [IDX_W-1:0]     r_quo;
    t_slc_out             r_out;
    logic [META_W-1:0]    r_meta_q;
    logic [TROW_W-1:0]    r_trow_q;

    logic [META_W-1:0]    meta_mem [NUM_SETS];
    logic [TROW_W-1:0]    tag_mem  [NUM_SETS];

    logic                        in_acc;
    logic                        out_free;
    logic                        upd_fire;
    logic signed [ADDR_BITS-1:0] off_ext;
    logic [ADDR_BITS-1:0]        ea_sum;
    logic [3:0]                  ib_eff;
    logic [ADDR_BITS-1:0]        ea_sh;
    logic [IDX_W-1:0]            idx_mask;
    logic [IDX_W-1:0]            idx_c;
    logic [TAG_W-1:0]            tag_c;
    logic [IDX_W+SAW-1:0]        idx_ext;
    logic [SAW-1:0]              set_pow2;
    logic [PRD_W-1:0]            quo_prod;
    logic [IDX_W-1:0]            quo_c;
    logic [IDX_W-1:0]            rem_c;
    logic [5:0]                  ways_ext;
    logic [5:0]                  ways_eff;
    t_slc_status                 status;
    logic [TROW_W-1:0]           n_trow;
    logic [MAX_WAYS-1:0]         n_valid;
    logic [MAX_WAYS*RW-1:0]      n_ranks;
    logic [CNT_W-1:0]            n_hit_cnt;
    logic [CNT_W-1:0]            n_miss_cnt;
    logic                        meta_we;
    logic [SAW-1:0]              meta_wa;
    logic [META_W-1:0]           meta_wd;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = r_state != S_IDLE;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign upd_fire    = r_state == S_UPD && out_free;

    assign off_ext  = ADDR_BITS'(i_in_data.address_offset);
    assign ea_sum   = ADDR_BITS'(i_in_data.base_address) + off_ext;
    assign ib_eff   = r_ib > IDX_BITS_CAP ? IDX_BITS_CAP : r_ib;
    assign ea_sh    = r_ea >> r_ob;
    assign idx_mask = IDX_W'((13'd1 << ib_eff) - 13'd1);
    assign idx_c    = IDX_W'(ea_sh) & idx_mask;
    assign tag_c    = TAG_W'(r_ea >> (6'(r_ob) + 6'(ib_eff)));
    assign idx_ext  = (IDX_W + SAW)'(idx_c);
    assign set_pow2 = NUM_SETS == 1 ? '0 : idx_ext[SAW-1:0];

    assign quo_prod = PRD_W'(r_idx) * PRD_W'(RCP_M);
    assign quo_c    = IDX_W'(quo_prod >> RCP_SH);
    assign rem_c    = r_idx - IDX_W'(r_quo * SETS_LO);

    assign ways_ext = 6'(r_ways);
    assign ways_eff = ways_ext == 6'd0 ? 6'd1 :
                      (ways_ext > 6'(MAX_WAYS) ? 6'(MAX_WAYS) : ways_ext);

    slc_way_logic #(
        .MAX_WAYS(MAX_WAYS),
        .RW      (RW),
        .WW      (WW)
    ) u_way (
        .i_tag_row(r_trow_q),
        .i_valid  (r_meta_q[MAX_WAYS*RW +: MAX_WAYS]),
        .i_ranks  (r_meta_q[MAX_WAYS*RW-1:0]),
        .i_tag    (r_tag),
        .i_ways   (ways_eff),
        .o_status (status),
        .o_tag_row(n_trow),
        .o_valid  (n_valid),
        .o_ranks  (n_ranks)
    );

    assign n_hit_cnt  = (status.hit && r_hit_cnt != '1) ? r_hit_cnt + CNT_W'(1) : r_hit_cnt;
    assign n_miss_cnt = (!status.hit && r_miss_cnt != '1) ? r_miss_cnt + CNT_W'(1)
                                                          : r_miss_cnt;

    assign meta_we = r_state == S_CLR || upd_fire;
    assign meta_wa = r_state == S_CLR ? r_clr : r_set;
    assign meta_wd = r_state == S_CLR ? '0 : {n_valid, n_ranks};

    always_ff @(posedge i_clk) begin
        if (meta_we) begin
            meta_mem[meta_wa] <= meta_wd;
        end
        if (r_state == S_RD) begin
            r_meta_q <= meta_mem[r_set];
        end
    end

    always_ff @(posedge i_clk) begin
        if (upd_fire && !status.hit) begin
            tag_mem[r_set] <= n_trow;
        end
        if (r_state == S_RD) begin
            r_trow_q <= tag_mem[r_set];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR: begin
                if (r_clr == SAW'(NUM_SETS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_ADDR;
                end
            end
            S_ADDR: begin
                n_state = SETS_POW2 ? S_RD : S_MOD;
            end
            S_MOD: begin
                if (r_mod_cnt == MCW'(MOD_STEPS - 1)) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_mod_cnt   <= '0;
            r_out_valid <= 1'b0;
            r_hit_cnt   <= '0;
            r_miss_cnt  <= '0;
            r_ob        <= RST_OFFSET_BITS;
            r_ib        <= RST_INDEX_BITS;
            r_ways      <= RST_WAYS_USED;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) begin
                r_clr <= r_clr + SAW'(1);
            end
            if (r_state == S_MOD) begin
                r_mod_cnt <= r_mod_cnt + MCW'(1);
            end else begin
                r_mod_cnt <= '0;
            end
            if (upd_fire) begin
                r_out_valid <= 1'b1;
                r_hit_cnt   <= n_hit_cnt;
                r_miss_cnt  <= n_miss_cnt;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_OFFSET_BITS: r_ob   <= i_cfg_data;
                    REG_INDEX_BITS:  r_ib   <= i_cfg_data[3:0];
                    REG_WAYS_USED:   r_ways <= i_cfg_data[3:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_ea <= ea_sum;
        end
        if (r_state == S_ADDR) begin
            r_idx <= idx_c;
            r_tag <= tag_c;
            if (SETS_POW2) begin
                r_set <= set_pow2;
            end
        end
        if (r_state == S_MOD) begin
            if (r_mod_cnt == MCW'(MOD_STEPS - 1)) begin
                r_set <= SAW'(rem_c);
            end else begin
                r_quo <= quo_c;
            end
        end
        if (upd_fire) begin
            r_out.hit        <= status.hit;
            r_out.evicted    <= status.evicted;
            r_out.set_index  <= r_idx;
            r_out.line_tag   <= r_tag;
            r_out.hit_total  <= n_hit_cnt;
            r_out.miss_total <= n_miss_cnt;
        end
    end

endmodule

// ===== rtl/slc_way_logic.sv =====
// Way search and LRU update for one set row of the cache tag store.
// Depends on slc_pkg for the tag width and the status type.
module slc_way_logic import slc_pkg::*; #(
    parameter int MAX_WAYS = SLC_MAX_WAYS,
    parameter int RW       = 3,
    parameter int WW       = 3
) (
    input  logic [MAX_WAYS*TAG_W-1:0] i_tag_row,
    input  logic [MAX_WAYS-1:0]       i_valid,
    input  logic [MAX_WAYS*RW-1:0]    i_ranks,
    input  logic [TAG_W-1:0]          i_tag,
    input  logic [5:0]                i_ways,
    output t_slc_status               o_status,
    output logic [MAX_WAYS*TAG_W-1:0] o_tag_row,
    output logic [MAX_WAYS-1:0]       o_valid,
    output logic [MAX_WAYS*RW-1:0]    o_ranks
);

    localparam logic [RW-1:0] RANK_TOP = RW'(MAX_WAYS - 1);

    logic [MAX_WAYS-1:0] in_range;
    logic                hit;
    logic                free;
    logic [WW-1:0]       hit_way;
    logic [WW-1:0]       free_way;
    logic [WW-1:0]       old_way;
    logic [WW-1:0]       victim;
    logic [RW-1:0]       hit_rank;
    logic [RW-1:0]       best;
    logic [RW:0]         below;
    logic                evict;
    logic [RW-1:0]       rank_w;
    logic                live;

    always_comb begin
        hit      = 1'b0;
        free     = 1'b0;
        hit_way  = '0;
        free_way = '0;
        old_way  = '0;
        hit_rank = '0;
        best     = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            in_range[w] = 6'(w) < i_ways;
        end
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (!hit && in_range[w] && i_valid[w] && i_tag_row[w*TAG_W +: TAG_W] == i_tag) begin
                hit      = 1'b1;
                hit_way  = WW'(w);
                hit_rank = i_ranks[w*RW +: RW];
            end
        end
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (!free && in_range[w] && !i_valid[w]) begin
                free     = 1'b1;
                free_way = WW'(w);
            end
        end
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (in_range[w] && (w == 0 || i_ranks[w*RW +: RW] > best)) begin
                best    = i_ranks[w*RW +: RW];
                old_way = WW'(w);
            end
        end
        evict  = !hit && !free;
        victim = hit ? hit_way : (free ? free_way : old_way);
        below  = hit ? {1'b0, hit_rank} : '1;

        o_tag_row = i_tag_row;
        o_valid   = i_valid;
        o_ranks   = i_ranks;
        for (int w = 0; w < MAX_WAYS; w++) begin
            rank_w = i_ranks[w*RW +: RW];
            live   = i_valid[w] && !(evict && WW'(w) == victim);
            if (in_range[w] && live && {1'b0, rank_w} < below && rank_w < RANK_TOP) begin
                o_ranks[w*RW +: RW] = rank_w + RW'(1);
            end
            if (WW'(w) == victim) begin
                o_ranks[w*RW +: RW] = '0;
                o_valid[w]          = 1'b1;
                if (!hit) begin
                    o_tag_row[w*TAG_W +: TAG_W] = i_tag;
                end
            end
        end
        o_status.hit     = hit;
        o_status.evicted = evict;
    end

endmodule

// ===== rtl/slc_checker.sv =====
// Port checker for the cache tag store, bound to the top level.
// Depends on slc_pkg for the word types.
module slc_checker import slc_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_valid,
    input logic     o_in_stall,
    input logic     o_out_valid,
    input logic     i_out_stall,
    input t_slc_out o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output word changed");

    a_hit_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.hit && o_out_data.evicted))
        else $error("hit and eviction reported together");

    a_totals: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.hit ? o_out_data.hit_total != 32'd0
                                         : o_out_data.miss_total != 32'd0))
        else $error("total does not count the reported access");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second word accepted while an access is in flight");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind set_assoc_lru_cache_tags slc_checker u_slc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_data (o_out_data)
);
